@@ design/spq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the stable priority queue cell chain.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int PRIO_W = 16;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;
    localparam int PAYLOAD_W = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ  = 2'd0,
        CMD_DEQ  = 2'd1,
        CMD_PEEK = 2'd2,
        CMD_NOP  = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // broadcast to every cell in the chain
    typedef struct packed {
        logic                     enq;
        logic                     deq;
        logic signed [PRIO_W-1:0] new_prio;
    } cell_ctrl_t;

endpackage
`default_nettype wire

@@ design/spq_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, compares it with the new
// priority and shifts toward its left or right neighbor.
// ----------------------------------------------------------------------------
module spq_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  wire                                 clk,
    input  wire spq_pkg::cell_ctrl_t            ctrl,
    input  wire        [DATA_WIDTH-1:0]         new_data,
    input  wire                                 occupied,
    input  wire                                 at_tail,
    input  wire                                 left_gt,
    input  wire signed [spq_pkg::PRIO_W-1:0]    left_prio,
    input  wire        [DATA_WIDTH-1:0]         left_data,
    input  wire signed [spq_pkg::PRIO_W-1:0]    right_prio,
    input  wire        [DATA_WIDTH-1:0]         right_data,
    output logic signed [spq_pkg::PRIO_W-1:0]   prio,
    output logic       [DATA_WIDTH-1:0]         data,
    output logic                                gt
);

    logic signed [spq_pkg::PRIO_W-1:0] prio_reg;
    logic signed [spq_pkg::PRIO_W-1:0] prio_next;
    logic        [DATA_WIDTH-1:0]      data_reg;
    logic        [DATA_WIDTH-1:0]      data_next;

    // strictly greater keeps equal priorities in arrival order
    assign gt   = occupied && (prio_reg > ctrl.new_prio);
    assign prio = prio_reg;
    assign data = data_reg;

    always_comb
    begin
        prio_next = prio_reg;
        data_next = data_reg;
        if (ctrl.enq)
        begin
            if (gt || at_tail)
            begin
                if (left_gt)
                begin
                    prio_next = left_prio;
                    data_next = left_data;
                end
                else
                begin
                    prio_next = ctrl.new_prio;
                    data_next = new_data;
                end
            end
        end
        else if (ctrl.deq)
        begin
            prio_next = right_prio;
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg <= prio_next;
        data_reg <= data_next;
    end

endmodule
`default_nettype wire

@@ design/stable_priority_queue_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// the result of each accepted input transaction is in the output register in the next cycle
// throughput: one command per cycle while s_tready is high; every cell compares and shifts in parallel
// a full result register that is not taken holds off the input side
// reset: entry count and output valid clear asynchronously; cell contents stay undefined
// and are never read before written
// ----------------------------------------------------------------------------
// stable_priority_queue_top
// Bounded stable min priority queue built as a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
module stable_priority_queue_top #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [47:0] s_tdata,   // priority_in[15:0], payload_in[47:16]
    input  wire  [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [55:0] m_tdata,   // payload_out[31:0], priority_out[47:32],
                                   // occupancy[52:48], zero[55:53]
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PW    = spq_pkg::PRIO_W;

    logic                  acc;
    spq_pkg::cmd_t         cmd;
    logic signed [PW-1:0]  in_prio;
    logic [63:0]           in_data64;
    logic [DATA_WIDTH-1:0] new_data;

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  full;
    logic                  empty;
    spq_pkg::cell_ctrl_t   ctrl;

    logic signed [PW-1:0]  cell_prio [DEPTH];
    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic                  cell_gt   [DEPTH];

    logic                  out_valid_reg;
    spq_pkg::status_t      status_reg;
    spq_pkg::status_t      status_next;
    logic [31:0]           pay_reg;
    logic [31:0]           pay_next;
    logic signed [PW-1:0]  prio_reg;
    logic signed [PW-1:0]  prio_next;
    logic [spq_pkg::OCC_W-1:0] occ_reg;
    logic [31:0]           count32;
    logic [63:0]           front64;

    assign s_tready  = !out_valid_reg || m_tready;
    assign acc       = s_tvalid && s_tready;
    assign cmd       = spq_pkg::cmd_t'(s_tuser);
    assign in_prio   = s_tdata[15:0];
    assign in_data64 = {32'd0, s_tdata[47:16]};
    assign new_data  = in_data64[DATA_WIDTH-1:0];

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    assign ctrl.enq      = acc && (cmd == spq_pkg::CMD_ENQ) && !full;
    assign ctrl.deq      = acc && (cmd == spq_pkg::CMD_DEQ) && !empty;
    assign ctrl.new_prio = in_prio;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic                  l_gt;
            logic signed [PW-1:0]  l_prio;
            logic [DATA_WIDTH-1:0] l_data;
            logic signed [PW-1:0]  r_prio;
            logic [DATA_WIDTH-1:0] r_data;

            if (gi == 0)
            begin : g_first
                assign l_gt   = 1'b0;
                assign l_prio = in_prio;
                assign l_data = new_data;
            end
            else
            begin : g_mid
                assign l_gt   = cell_gt[gi-1];
                assign l_prio = cell_prio[gi-1];
                assign l_data = cell_data[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign r_prio = '0;
                assign r_data = '0;
            end
            else
            begin : g_inner
                assign r_prio = cell_prio[gi+1];
                assign r_data = cell_data[gi+1];
            end

            spq_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .new_data   (new_data),
                .occupied   (count_reg > CNT_W'(gi)),
                .at_tail    (count_reg == CNT_W'(gi)),
                .left_gt    (l_gt),
                .left_prio  (l_prio),
                .left_data  (l_data),
                .right_prio (r_prio),
                .right_data (r_data),
                .prio       (cell_prio[gi]),
                .data       (cell_data[gi]),
                .gt         (cell_gt[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.enq)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.deq)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign front64 = 64'(cell_data[0]);
    assign count32 = 32'(count_next);

    always_comb
    begin
        status_next = spq_pkg::ST_OK;
        pay_next    = '0;
        prio_next   = '0;
        case (cmd)
            spq_pkg::CMD_ENQ:
            begin
                if (full)
                begin
                    status_next = spq_pkg::ST_FULL;
                end
            end
            spq_pkg::CMD_DEQ, spq_pkg::CMD_PEEK:
            begin
                if (empty)
                begin
                    status_next = spq_pkg::ST_EMPTY;
                end
                else
                begin
                    pay_next  = front64[31:0];
                    prio_next = cell_prio[0];
                end
            end
            default:
            begin
                status_next = spq_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (acc)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            status_reg <= status_next;
            pay_reg    <= pay_next;
            prio_reg   <= prio_next;
            occ_reg    <= count32[spq_pkg::OCC_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {3'd0, occ_reg, prio_reg, pay_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && cmd == spq_pkg::CMD_ENQ && full) |=>
            (status_reg == spq_pkg::ST_FULL) && $stable(count_reg))
        else $error("enqueue into full queue not rejected");

    a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && cmd == spq_pkg::CMD_DEQ && !empty) |=>
            (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("dequeue did not remove one entry");

    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        !acc |=> $stable(count_reg))
        else $error("entry count changed without a transaction");

endmodule
`default_nettype wire
